[src/ssoe_pkg.sv]
// shared types, function codes and defaults for the sorted set engine
package ssoe_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] FN_CLEAR     = 3'd0;
  localparam logic [2:0] FN_UNION     = 3'd1;
  localparam logic [2:0] FN_INTERSECT = 3'd2;
  localparam logic [2:0] FN_DIFF      = 3'd3;
  localparam logic [2:0] FN_COMPARE   = 3'd4;
  localparam logic [2:0] FN_MEMBER    = 3'd5;
  localparam logic [2:0] FN_READ      = 3'd6;

  localparam logic [1:0] ORD_EQUAL     = 2'd0;
  localparam logic [1:0] ORD_LESS      = 2'd1;
  localparam logic [1:0] ORD_GREATER   = 2'd2;
  localparam logic [1:0] ORD_UNORDERED = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

[src/ssoe_cmp.sv]
// shared two's complement magnitude comparator of the sorted set engine
module ssoe_cmp #(
  parameter int VALUE_BITS = ssoe_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  output ssoe_pkg::cmp_t        res
);
  import ssoe_pkg::*;

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = (a == b);
  end

endmodule

[src/sorted_set_operation_engine.sv]
// top level of the sorted set engine: sequencer, element store and result register
//
// The block holds set A as an ascending list of unique signed values in a store of
// CAPACITY words with one read and one write port, each word carrying a match mark
// next to the value. One item is taken at a time; in_tready is low while it is worked
// on. Clear goes straight to the result; read element first reads and captures the
// indexed word, unless the index is past the end of the set. Member query and every
// operand element with a value of union, intersect, difference and compare walk the
// list from the bottom with one shared comparator, one read and compare per stored
// element below the value; a union insert adds a read and a write per entry moved up.
// The item with tlast high then runs one pass over the whole set, a read and a write
// per stored element, that drops or keeps entries and clears the marks. A finished
// result sits in the output register, and the next item may be transferred meanwhile.
module sorted_set_operation_engine #(
  parameter int CAPACITY   = ssoe_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ssoe_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value [31:0], element_index [39:32], has_value [40], zero fill
  input  logic [47:0] in_tdata,
  // func [2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status [0], set_size [9:1], order [11:10], found [12], element [44:13],
  // element_valid [45], zero fill
  output logic [47:0] out_tdata
);
  import ssoe_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = $clog2(CAPACITY + 2);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int SW = (CW > 9) ? CW : 9;
  localparam int IW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int DW = VALUE_BITS + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_ACT      = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_MARK_WR  = 4'd7;
  localparam logic [3:0] S_AFTER    = 4'd8;
  localparam logic [3:0] S_FIN_RD   = 4'd9;
  localparam logic [3:0] S_FIN_WR   = 4'd10;
  localparam logic [3:0] S_FIN_END  = 4'd11;
  localparam logic [3:0] S_RD_EL    = 4'd12;
  localparam logic [3:0] S_RD_CAP   = 4'd13;
  localparam logic [3:0] S_RESULT   = 4'd14;

  logic [3:0] state_r;

  // latched item
  logic [2:0]            func_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [7:0]            idx_r;
  logic                  last_r;

  // set and stream state
  logic [CW-1:0] count_r;
  logic [CW-1:0] match_count_r;
  logic [OW-1:0] operand_count_r;
  logic          overflow_r;

  // walk pointers
  logic [CW-1:0] i_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] rp_r;
  logic [CW-1:0] wp_r;
  logic          hit_r;
  logic          mark_r;

  // staged result fields
  logic                  res_status_r;
  logic [1:0]            res_order_r;
  logic                  res_found_r;
  logic [31:0]           res_elem_r;
  logic                  res_evalid_r;

  // element store, mark in the top bit
  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          out_valid_r;
  logic [47:0]   out_data_r;

  cmp_t          cmp_res;
  logic          in_xfer;
  logic          keep;
  logic [IW-1:0] in_ext;
  logic [XW-1:0] idx_ext;
  logic [XW-1:0] cnt_xext;
  logic [SW-1:0] cnt_sext;
  logic [IW-1:0] rd_ext;
  logic [CW-1:0] j_dec;
  logic [CW-1:0] rp_inc;
  logic [OW-1:0] match_oext;

  ssoe_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
    .a   (rdata_r[VALUE_BITS-1:0]),
    .b   (val_r),
    .res (cmp_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_ext     = IW'($signed(in_tdata[31:0]));
  assign idx_ext    = XW'(idx_r);
  assign cnt_xext   = XW'(count_r);
  assign cnt_sext   = SW'(count_r);
  assign rd_ext     = IW'($signed(rdata_r[VALUE_BITS-1:0]));
  assign j_dec      = j_r - CW'(1);
  assign rp_inc     = rp_r + CW'(1);
  assign match_oext = OW'(match_count_r);

  // which entries survive the finishing pass
  always_comb begin
    unique case (func_r)
      FN_INTERSECT: keep = rdata_r[DW-1];
      FN_DIFF:      keep = !rdata_r[DW-1];
      default:      keep = 1'b1;
    endcase
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r[AW-1:0];
    mem_wdata = {1'b0, val_r};
    mem_raddr = i_r[AW-1:0];
    unique case (state_r)
      S_SHIFT_RD: mem_raddr = j_dec[AW-1:0];
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = rdata_r;
      end
      S_INS_WR:   mem_we = 1'b1;
      S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, val_r};
      end
      S_FIN_RD:   mem_raddr = rp_r[AW-1:0];
      S_FIN_WR: begin
        mem_we    = keep;
        mem_waddr = wp_r[AW-1:0];
        mem_wdata = {1'b0, rdata_r[VALUE_BITS-1:0]};
      end
      S_RD_EL:    mem_raddr = idx_ext[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // payload of the item and walk registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r       <= in_tuser;
      val_r        <= in_ext[VALUE_BITS-1:0];
      idx_r        <= in_tdata[39:32];
      last_r       <= in_tlast;
      i_r          <= '0;
      res_status_r <= 1'b0;
      res_order_r  <= ORD_EQUAL;
      res_found_r  <= 1'b0;
      res_elem_r   <= '0;
      res_evalid_r <= 1'b0;
    end
    unique case (state_r)
      S_SCAN_RD: begin
        if (i_r == count_r) begin
          pos_r <= count_r;
          hit_r <= 1'b0;
        end
      end
      S_SCAN_CMP: begin
        if (cmp_res.lt) begin
          i_r <= i_r + CW'(1);
        end else begin
          pos_r  <= i_r;
          hit_r  <= cmp_res.eq;
          mark_r <= rdata_r[DW-1];
        end
      end
      S_ACT: begin
        j_r <= count_r;
        if (func_r == FN_MEMBER) begin
          res_found_r <= hit_r;
        end
      end
      S_SHIFT_WR: j_r <= j_dec;
      S_AFTER: begin
        rp_r <= '0;
        wp_r <= '0;
      end
      S_FIN_WR: begin
        rp_r <= rp_inc;
        if (keep) begin
          wp_r <= wp_r + CW'(1);
        end
      end
      S_FIN_END: begin
        res_status_r <= overflow_r;
        if (func_r == FN_COMPARE) begin
          priority if (match_oext == operand_count_r && match_count_r == count_r) begin
            res_order_r <= ORD_EQUAL;
          end else if (match_count_r == count_r) begin
            res_order_r <= ORD_LESS;
          end else if (match_oext == operand_count_r) begin
            res_order_r <= ORD_GREATER;
          end else begin
            res_order_r <= ORD_UNORDERED;
          end
        end
      end
      S_RD_CAP: begin
        res_elem_r   <= rd_ext[31:0];
        res_evalid_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      count_r         <= '0;
      match_count_r   <= '0;
      operand_count_r <= '0;
      overflow_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // a waiting result is reloaded by the result state instead
      if (out_valid_r && out_tready && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_tuser)
              FN_CLEAR: begin
                count_r         <= '0;
                match_count_r   <= '0;
                operand_count_r <= '0;
                overflow_r      <= 1'b0;
                state_r         <= S_RESULT;
              end
              FN_MEMBER: state_r <= S_SCAN_RD;
              FN_READ: begin
                if (XW'(in_tdata[39:32]) < cnt_xext) begin
                  state_r <= S_RD_EL;
                end else begin
                  state_r <= S_RESULT;
                end
              end
              FN_UNION, FN_INTERSECT, FN_DIFF, FN_COMPARE: begin
                state_r <= in_tdata[40] ? S_SCAN_RD : S_AFTER;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN_RD:  state_r <= (i_r == count_r) ? S_ACT : S_SCAN_CMP;
        S_SCAN_CMP: state_r <= cmp_res.lt ? S_SCAN_RD : S_ACT;
        S_ACT: begin
          if (func_r == FN_MEMBER) begin
            state_r <= S_RESULT;
          end else if (func_r == FN_UNION) begin
            if (hit_r) begin
              state_r <= S_AFTER;
            end else if (count_r < CW'(CAPACITY)) begin
              state_r <= (count_r == pos_r) ? S_INS_WR : S_SHIFT_RD;
            end else begin
              overflow_r <= 1'b1;
              state_r    <= S_AFTER;
            end
          end else begin
            if (operand_count_r < OW'(CAPACITY + 1)) begin
              operand_count_r <= operand_count_r + OW'(1);
            end
            state_r <= (hit_r && !mark_r) ? S_MARK_WR : S_AFTER;
          end
        end
        S_SHIFT_RD: state_r <= S_SHIFT_WR;
        S_SHIFT_WR: state_r <= (j_dec == pos_r) ? S_INS_WR : S_SHIFT_RD;
        S_INS_WR: begin
          count_r <= count_r + CW'(1);
          state_r <= S_AFTER;
        end
        S_MARK_WR: begin
          match_count_r <= match_count_r + CW'(1);
          state_r       <= S_AFTER;
        end
        S_AFTER: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= (count_r == '0) ? S_FIN_END : S_FIN_RD;
          end
        end
        S_FIN_RD: state_r <= S_FIN_WR;
        S_FIN_WR: state_r <= (rp_inc == count_r) ? S_FIN_END : S_FIN_RD;
        S_FIN_END: begin
          // shrink to the entries written back, then drop the stream state
          if (count_r != '0) begin
            count_r <= wp_r;
          end
          match_count_r   <= '0;
          operand_count_r <= '0;
          overflow_r      <= 1'b0;
          state_r         <= S_RESULT;
        end
        S_RD_EL:  state_r <= S_RD_CAP;
        S_RD_CAP: state_r <= S_RESULT;
        S_RESULT: begin
          // wait for a free output register
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESULT && (!out_valid_r || out_tready)) begin
      out_data_r <= {2'b00, res_evalid_r, res_elem_r, res_found_r, res_order_r,
                     cnt_sext[8:0], res_status_r};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_marks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    match_count_r <= count_r)
    else $error("more marked entries than stored entries");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> j_r > pos_r)
    else $error("insert shift ran below insert position");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN_END |=> match_count_r == '0 && operand_count_r == '0 && !overflow_r)
    else $error("stream state not cleared after finish");
`endif

endmodule
